// File: hdl/sorted_adjacency_store_unit_macros.svh
`ifndef SORTED_ADJACENCY_STORE_UNIT_MACROS_SVH
`define SORTED_ADJACENCY_STORE_UNIT_MACROS_SVH

// condition holds at every clock edge outside reset
`define SAS_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// when the trigger holds, the consequence holds in the same cycle
`define SAS_ASSERT_IMPLY(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cons)) else $error(msg);

`endif

// File: hdl/sas_pkg.sv
`default_nettype none

package sas_pkg;

   localparam int NODE_SLOTS     = 64;
   localparam int DEF_MAX_DEGREE = 32;
   localparam int NODE_W         = 6;
   localparam int CNT_W          = 7;
   localparam int ID_IN_W        = 7;
   localparam int DEST_W         = 6;
   localparam int KIND_W         = 3;
   localparam int STATUS_W       = 2;
   localparam int REQ_DATA_W     = 16;
   localparam int RSP_DATA_W     = 16;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD_NODE = 3'd0,
      KIND_DEL_NODE = 3'd1,
      KIND_DEL_KEEP = 3'd2,
      KIND_ADD_EDGE = 3'd3,
      KIND_DEL_EDGE = 3'd4,
      KIND_TEST     = 3'd5,
      KIND_LIST     = 3'd6,
      KIND_CLEAR    = 3'd7
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE   = 2'd0,
      STAT_REJECT = 2'd1,
      STAT_DUP    = 2'd2,
      STAT_FULL   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      RES_PLAIN = 3'd0,
      RES_ALLOC = 3'd1,
      RES_POP   = 3'd2,
      RES_TEST  = 3'd3,
      RES_LIST  = 3'd4
   } res_src_type;

   typedef enum logic [1:0] {
      ERD_P    = 2'd0,
      ERD_DOWN = 2'd1,
      ERD_UP   = 2'd2
   } erd_type;

   typedef enum logic [1:0] {
      EWR_NONE  = 2'd0,
      EWR_SHIFT = 2'd1,
      EWR_PUT   = 2'd2
   } ewr_type;

   typedef enum logic [1:0] {
      DWR_NONE = 2'd0,
      DWR_INC  = 2'd1,
      DWR_DEC  = 2'd2
   } dwr_type;

   typedef struct packed {
      logic        take;
      logic        n_from_s;
      logic        n_clr;
      logic        n_inc;
      logic        p_clr;
      logic        p_inc;
      logic        i_from_deg;
      logic        i_from_p;
      logic        i_dec;
      logic        i_inc;
      logic        deg_load;
      logic        hit_load;
      logic        hit_clr;
      erd_type     erd;
      ewr_type     ewr;
      dwr_type     dwr;
      logic        alloc_new;
      logic        pop;
      logic        retire;
      logic        clear_all;
      logic        res_set;
      res_src_type res_src;
      status_type  res_status;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     s_ok;
      logic     d_ok;
      logic     free_empty;
      logic     alloc_full;
      logic     deg_zero;
      logic     deg_full;
      logic     p_at_deg;
      logic     rd_lt;
      logic     hit;
      logic     i_at_p;
      logic     del_end;
      logic     n_end;
      logic     n_ok;
      logic     last_pend;
      logic     out_free;
   } sts_type;

endpackage

`default_nettype wire

// File: hdl/sas_datapath.sv
`default_nettype none

`include "sorted_adjacency_store_unit_macros.svh"

module sas_datapath
   import sas_pkg::*;
#(
   parameter int MAX_DEGREE = DEF_MAX_DEGREE
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output sts_type                    sts,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [KIND_W-1:0]     req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast
);

   localparam int DEG_W  = $clog2(MAX_DEGREE + 1);
   localparam int DEPTH  = NODE_SLOTS * MAX_DEGREE;
   localparam int ADDR_W = $clog2(DEPTH);

   kind_type               kind_ff;
   logic [ID_IN_W-1:0]     s_ff, d_ff, tgt;
   logic [CNT_W-1:0]       n_ff, n_in;
   logic [DEG_W-1:0]       p_ff, i_ff, deg_ff, deg_cur, deg_rd_ff, erd_idx, ewr_idx;
   logic                   hit_ff;
   logic [CNT_W-1:0]       alloc_ff, top_ff, top_dec;
   logic [NODE_SLOTS-1:0]  active_ff, deg_vld_ff;
   logic [DEST_W-1:0]      edge_rd_ff, fs_rd_ff, ewr_data;
   logic [ADDR_W-1:0]      seg_base, erd_addr, ewr_addr;
   logic                   rd_eq, res_last;

   logic [DEST_W-1:0]      edge_mem [DEPTH];
   logic [DEG_W-1:0]       deg_mem  [NODE_SLOTS];
   logic [NODE_W-1:0]      fs_mem   [NODE_SLOTS];

   logic [NODE_W-1:0]      r_id_ff, r_id_in;
   status_type             r_status_ff, r_status_in;
   logic                   r_found_ff, r_found_in, r_last_ff, r_last_in;
   logic [DEST_W-1:0]      r_dest_ff, r_dest_in;

   logic                   out_valid_ff;
   logic [RSP_DATA_W-1:0]  out_data_ff;
   logic                   out_last_ff;

   // node index and scan pointers
   always_comb begin
      n_in = n_ff;
      if (cmd.n_from_s) begin
         n_in = s_ff;
      end else if (cmd.n_clr) begin
         n_in = '0;
      end else if (cmd.n_inc) begin
         n_in = n_ff + CNT_W'(1);
      end
   end

   assign tgt      = (kind_ff == KIND_DEL_NODE) ? s_ff : d_ff;
   assign deg_cur  = deg_vld_ff[n_ff[NODE_W-1:0]] ? deg_rd_ff : '0;
   assign top_dec  = top_ff - CNT_W'(1);
   assign seg_base = ADDR_W'(ADDR_W'(n_ff[NODE_W-1:0]) * ADDR_W'(MAX_DEGREE));
   assign rd_eq    = ({1'b0, edge_rd_ff} == tgt);
   assign res_last = ((p_ff + DEG_W'(1)) == deg_ff);

   always_comb begin
      case (cmd.erd)
         ERD_DOWN: erd_idx = i_ff - DEG_W'(1);
         ERD_UP:   erd_idx = i_ff + DEG_W'(1);
         default:  erd_idx = p_ff;
      endcase
      if (cmd.ewr == EWR_PUT) begin
         ewr_idx  = p_ff;
         ewr_data = tgt[DEST_W-1:0];
      end else begin
         ewr_idx  = i_ff;
         ewr_data = edge_rd_ff;
      end
      erd_addr = seg_base + ADDR_W'(erd_idx);
      ewr_addr = seg_base + ADDR_W'(ewr_idx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff   <= '0;
         p_ff   <= '0;
         i_ff   <= '0;
         deg_ff <= '0;
         hit_ff <= 1'b0;
      end else begin
         n_ff <= n_in;
         if (cmd.p_clr) begin
            p_ff <= '0;
         end else if (cmd.p_inc) begin
            p_ff <= p_ff + DEG_W'(1);
         end
         if (cmd.i_from_deg) begin
            i_ff <= deg_ff;
         end else if (cmd.i_from_p) begin
            i_ff <= p_ff;
         end else if (cmd.i_dec) begin
            i_ff <= i_ff - DEG_W'(1);
         end else if (cmd.i_inc) begin
            i_ff <= i_ff + DEG_W'(1);
         end
         if (cmd.deg_load) begin
            deg_ff <= deg_cur;
         end
         if (cmd.hit_clr) begin
            hit_ff <= 1'b0;
         end else if (cmd.hit_load) begin
            hit_ff <= rd_eq;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         kind_ff <= kind_type'(req_tuser);
         s_ff    <= req_tdata[ID_IN_W-1:0];
         d_ff    <= req_tdata[2*ID_IN_W-1:ID_IN_W];
      end
   end

   // edge segments
   always_ff @(posedge clock) begin
      if (cmd.ewr != EWR_NONE) begin
         edge_mem[ewr_addr] <= ewr_data;
      end
      edge_rd_ff <= edge_mem[erd_addr];
   end

   // node degrees, a clear valid bit reads as zero
   always_ff @(posedge clock) begin
      if (cmd.dwr == DWR_INC) begin
         deg_mem[n_ff[NODE_W-1:0]] <= deg_ff + DEG_W'(1);
      end else if (cmd.dwr == DWR_DEC) begin
         deg_mem[n_ff[NODE_W-1:0]] <= deg_ff - DEG_W'(1);
      end
      deg_rd_ff <= deg_mem[n_in[NODE_W-1:0]];
   end

   // free id stack
   always_ff @(posedge clock) begin
      if (cmd.retire && (top_ff < CNT_W'(NODE_SLOTS))) begin
         fs_mem[top_ff[NODE_W-1:0]] <= s_ff[NODE_W-1:0];
      end
      fs_rd_ff <= fs_mem[top_dec[NODE_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_all) begin
         alloc_ff   <= '0;
         top_ff     <= '0;
         active_ff  <= '0;
         deg_vld_ff <= '0;
      end else begin
         if (cmd.alloc_new) begin
            alloc_ff                              <= alloc_ff + CNT_W'(1);
            active_ff[alloc_ff[NODE_W-1:0]]       <= 1'b1;
            deg_vld_ff[alloc_ff[NODE_W-1:0]]      <= 1'b0;
         end
         if (cmd.pop) begin
            top_ff                     <= top_dec;
            active_ff[fs_rd_ff]        <= 1'b1;
            deg_vld_ff[fs_rd_ff]       <= 1'b0;
         end
         if (cmd.retire) begin
            if (top_ff < CNT_W'(NODE_SLOTS)) begin
               top_ff <= top_ff + CNT_W'(1);
            end
            active_ff[s_ff[NODE_W-1:0]]  <= 1'b0;
            deg_vld_ff[s_ff[NODE_W-1:0]] <= 1'b0;
         end
         if (cmd.dwr != DWR_NONE) begin
            deg_vld_ff[n_ff[NODE_W-1:0]] <= 1'b1;
         end
      end
   end

   // pending result
   always_comb begin
      r_id_in     = '0;
      r_status_in = cmd.res_status;
      r_found_in  = 1'b0;
      r_dest_in   = '0;
      r_last_in   = 1'b1;
      case (cmd.res_src)
         RES_ALLOC: r_id_in = alloc_ff[NODE_W-1:0];
         RES_POP:   r_id_in = fs_rd_ff;
         RES_TEST: begin
            r_status_in = hit_ff ? STAT_DONE : STAT_REJECT;
            r_found_in  = hit_ff;
         end
         RES_LIST: begin
            r_found_in = 1'b1;
            r_dest_in  = edge_rd_ff;
            r_last_in  = res_last;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.res_set) begin
         r_id_ff     <= r_id_in;
         r_status_ff <= r_status_in;
         r_found_ff  <= r_found_in;
         r_dest_ff   <= r_dest_in;
         r_last_ff   <= r_last_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_data_ff <= {1'b0, r_dest_ff, r_found_ff, r_status_ff, r_id_ff};
         out_last_ff <= r_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   always_comb begin
      sts.kind       = kind_ff;
      sts.s_ok       = (s_ff < alloc_ff) && active_ff[s_ff[NODE_W-1:0]];
      sts.d_ok       = (d_ff < alloc_ff) && active_ff[d_ff[NODE_W-1:0]];
      sts.free_empty = (top_ff == '0);
      sts.alloc_full = (alloc_ff == CNT_W'(NODE_SLOTS));
      sts.deg_zero   = (deg_cur == '0);
      sts.deg_full   = (deg_ff == DEG_W'(MAX_DEGREE));
      sts.p_at_deg   = (p_ff == deg_ff);
      sts.rd_lt      = ({1'b0, edge_rd_ff} < tgt);
      sts.hit        = hit_ff;
      sts.i_at_p     = (i_ff == p_ff);
      sts.del_end    = ((i_ff + DEG_W'(1)) == deg_ff);
      sts.n_end      = (n_ff == alloc_ff);
      sts.n_ok       = active_ff[n_ff[NODE_W-1:0]] && (n_ff != s_ff);
      sts.last_pend  = r_last_ff;
      sts.out_free   = !out_valid_ff || rsp_tready;
   end

   `SAS_ASSERT_ALWAYS(a_free_le_alloc, top_ff <= alloc_ff, "free stack deeper than allocated ids")
   `SAS_ASSERT_ALWAYS(a_deg_bound, deg_ff <= DEG_W'(MAX_DEGREE), "degree above segment size")
   `SAS_ASSERT_IMPLY(a_shift_in_seg, cmd.ewr != EWR_NONE, ewr_idx < DEG_W'(MAX_DEGREE),
      "edge write outside segment")

endmodule

`default_nettype wire

// File: hdl/sas_control.sv
`default_nettype none

module sas_control
   import sas_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_tvalid,
   output logic         req_tready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   typedef enum logic [13:0] {
      ST_IDLE    = 14'b00000000000001,
      ST_DECODE  = 14'b00000000000010,
      ST_DEGRD   = 14'b00000000000100,
      ST_SREAD   = 14'b00000000001000,
      ST_SCMP    = 14'b00000000010000,
      ST_SDONE   = 14'b00000000100000,
      ST_INS_RD  = 14'b00000001000000,
      ST_INS_WR  = 14'b00000010000000,
      ST_DEL_RD  = 14'b00000100000000,
      ST_DEL_WR  = 14'b00001000000000,
      ST_NODESEL = 14'b00010000000000,
      ST_LREAD   = 14'b00100000000000,
      ST_LOUT    = 14'b01000000000000,
      ST_EMIT    = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.take = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_EMIT;
            case (sts.kind)
               KIND_ADD_NODE: begin
                  cmd.res_set = 1'b1;
                  if (!sts.free_empty) begin
                     cmd.pop     = 1'b1;
                     cmd.res_src = RES_POP;
                  end else if (!sts.alloc_full) begin
                     cmd.alloc_new = 1'b1;
                     cmd.res_src   = RES_ALLOC;
                  end else begin
                     cmd.res_status = STAT_FULL;
                  end
               end
               KIND_CLEAR: begin
                  cmd.clear_all = 1'b1;
                  cmd.res_set   = 1'b1;
               end
               default: begin
                  if (!sts.s_ok || (sts.kind == KIND_ADD_EDGE && !sts.d_ok)) begin
                     cmd.res_set    = 1'b1;
                     cmd.res_status = STAT_REJECT;
                  end else if (sts.kind == KIND_DEL_NODE) begin
                     cmd.n_clr = 1'b1;
                     state_in  = ST_NODESEL;
                  end else if (sts.kind == KIND_DEL_KEEP) begin
                     cmd.retire  = 1'b1;
                     cmd.res_set = 1'b1;
                  end else begin
                     cmd.n_from_s = 1'b1;
                     state_in     = ST_DEGRD;
                  end
               end
            endcase
         end
         ST_DEGRD: begin
            cmd.deg_load = 1'b1;
            cmd.p_clr    = 1'b1;
            if (sts.kind == KIND_LIST) begin
               if (sts.deg_zero) begin
                  cmd.res_set = 1'b1;
                  state_in    = ST_EMIT;
               end else begin
                  state_in = ST_LREAD;
               end
            end else begin
               state_in = ST_SREAD;
            end
         end
         ST_SREAD: begin
            if (sts.p_at_deg) begin
               cmd.hit_clr = 1'b1;
               state_in    = ST_SDONE;
            end else begin
               cmd.erd  = ERD_P;
               state_in = ST_SCMP;
            end
         end
         ST_SCMP: begin
            if (sts.rd_lt) begin
               cmd.p_inc = 1'b1;
               state_in  = ST_SREAD;
            end else begin
               cmd.hit_load = 1'b1;
               state_in     = ST_SDONE;
            end
         end
         ST_SDONE: begin
            state_in = ST_EMIT;
            case (sts.kind)
               KIND_TEST: begin
                  cmd.res_set = 1'b1;
                  cmd.res_src = RES_TEST;
               end
               KIND_ADD_EDGE: begin
                  if (sts.hit) begin
                     cmd.res_set    = 1'b1;
                     cmd.res_status = STAT_DUP;
                  end else if (sts.deg_full) begin
                     cmd.res_set    = 1'b1;
                     cmd.res_status = STAT_FULL;
                  end else begin
                     cmd.i_from_deg = 1'b1;
                     state_in       = ST_INS_RD;
                  end
               end
               KIND_DEL_EDGE: begin
                  if (sts.hit) begin
                     cmd.i_from_p = 1'b1;
                     state_in     = ST_DEL_RD;
                  end else begin
                     cmd.res_set    = 1'b1;
                     cmd.res_status = STAT_REJECT;
                  end
               end
               KIND_DEL_NODE: begin
                  if (sts.hit) begin
                     cmd.i_from_p = 1'b1;
                     state_in     = ST_DEL_RD;
                  end else begin
                     cmd.n_inc = 1'b1;
                     state_in  = ST_NODESEL;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_INS_RD: begin
            if (sts.i_at_p) begin
               cmd.ewr     = EWR_PUT;
               cmd.dwr     = DWR_INC;
               cmd.res_set = 1'b1;
               state_in    = ST_EMIT;
            end else begin
               cmd.erd  = ERD_DOWN;
               state_in = ST_INS_WR;
            end
         end
         ST_INS_WR: begin
            cmd.ewr   = EWR_SHIFT;
            cmd.i_dec = 1'b1;
            state_in  = ST_INS_RD;
         end
         ST_DEL_RD: begin
            if (sts.del_end) begin
               cmd.dwr = DWR_DEC;
               if (sts.kind == KIND_DEL_NODE) begin
                  cmd.n_inc = 1'b1;
                  state_in  = ST_NODESEL;
               end else begin
                  cmd.res_set = 1'b1;
                  state_in    = ST_EMIT;
               end
            end else begin
               cmd.erd  = ERD_UP;
               state_in = ST_DEL_WR;
            end
         end
         ST_DEL_WR: begin
            cmd.ewr   = EWR_SHIFT;
            cmd.i_inc = 1'b1;
            state_in  = ST_DEL_RD;
         end
         ST_NODESEL: begin
            if (sts.n_end) begin
               cmd.retire  = 1'b1;
               cmd.res_set = 1'b1;
               state_in    = ST_EMIT;
            end else if (sts.n_ok) begin
               state_in = ST_DEGRD;
            end else begin
               cmd.n_inc = 1'b1;
            end
         end
         ST_LREAD: begin
            cmd.erd  = ERD_P;
            state_in = ST_LOUT;
         end
         ST_LOUT: begin
            cmd.res_set = 1'b1;
            cmd.res_src = RES_LIST;
            cmd.p_inc   = 1'b1;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = sts.last_pend ? ST_IDLE : ST_LREAD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/sorted_adjacency_store_unit.sv
// add node, clear, rejects and keeping removal settle their result in the decode state,
// load it in the emit state once the output is free, and then take the next item in idle
// test, add and remove edge scan the sorted edges of the source node one at a time
// listing emits one result at a time; purging removal walks all allocated nodes
// one item is worked at a time, set by the serial search and shift through the edge segments
// reset (synchronous, active high) empties the store; no clearing pass is needed
`default_nettype none

module sorted_adjacency_store_unit
   import sas_pkg::*;
#(
   parameter int MAX_DEGREE = DEF_MAX_DEGREE
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // src_node, dst_node
   input  wire logic [KIND_W-1:0]     req_tuser,   // kind
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // node_id, status, found, dest
   output logic                       rsp_tlast
);

   cmd_type cmd;
   sts_type sts;

   sas_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   sas_datapath #(
      .MAX_DEGREE (MAX_DEGREE)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// File: tb/sorted_adjacency_store_unit_tb.sv
`default_nettype none

module sorted_adjacency_store_unit_tb;
   import sas_pkg::*;

   localparam int MAXDEG = DEF_MAX_DEGREE;
   localparam int STALL_LIMIT = 40000;

   typedef struct packed {
      logic [5:0] node_id;
      status_type status;
      logic       found;
      logic [5:0] dest;
      logic       last;
   } graph_rsp_type;

   typedef struct {
      kind_type   kind;
      int         src;
      int         dst;
      bit         typed;
      status_type status;
      int         node_id;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [KIND_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tlast;

   sorted_adjacency_store_unit uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // graph model state
   bit         node_on[NODE_SLOTS];
   int         node_deg[NODE_SLOTS];
   logic [5:0] seg[NODE_SLOTS][MAXDEG];
   logic [5:0] free_ids[NODE_SLOTS];
   int         free_cnt;
   int         hiwater;

   graph_rsp_type pending_rsp[$];
   graph_rsp_type step_rsp[$];
   int errors = 0;
   int items_sent = 0;
   int rsp_seen = 0;
   int snd_idle = 0;
   int rcv_stall = 0;
   int quiet_cycles = 0;

   task automatic report_mismatch(input string msg);
      errors++;
      $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   function automatic void graph_reset();
      for (int i = 0; i < NODE_SLOTS; i++) begin
         node_on[i] = 0;
         node_deg[i] = 0;
      end
      free_cnt = 0;
      hiwater = 0;
   endfunction

   function automatic bit node_ok(int id);
      return id < hiwater && node_on[id];
   endfunction

   function automatic int edge_pos(int n, int d);
      int p;
      p = 0;
      while (p < node_deg[n] && seg[n][p] < d) p++;
      return p;
   endfunction

   function automatic bit edge_there(int n, int d);
      int p;
      p = edge_pos(n, d);
      return p < node_deg[n] && seg[n][p] == d;
   endfunction

   function automatic bit edge_drop(int n, int d);
      int p;
      p = edge_pos(n, d);
      if (p >= node_deg[n] || seg[n][p] != d) return 0;
      for (int i = p; i + 1 < node_deg[n]; i++) seg[n][i] = seg[n][i+1];
      node_deg[n]--;
      return 1;
   endfunction

   function automatic graph_rsp_type mk(int id, status_type st, bit f, int dst, bit l);
      graph_rsp_type r;
      r.node_id = id; r.status = st; r.found = f; r.dest = dst; r.last = l;
      return r;
   endfunction

   function automatic void graph_step(kind_type k, int s, int d);
      int id, p;
      step_rsp.delete();
      case (k)
         KIND_ADD_NODE: begin
            if (free_cnt > 0) begin
               free_cnt--;
               id = free_ids[free_cnt];
            end else if (hiwater < NODE_SLOTS) begin
               id = hiwater++;
            end else begin
               step_rsp.push_back(mk(0, STAT_FULL, 0, 0, 1));
               return;
            end
            node_on[id] = 1;
            node_deg[id] = 0;
            step_rsp.push_back(mk(id, STAT_DONE, 0, 0, 1));
         end
         KIND_DEL_NODE, KIND_DEL_KEEP: begin
            if (!node_ok(s)) begin
               step_rsp.push_back(mk(0, STAT_REJECT, 0, 0, 1));
               return;
            end
            if (k == KIND_DEL_NODE)
               for (int i = 0; i < hiwater; i++)
                  if (node_on[i] && i != s) void'(edge_drop(i, s));
            node_deg[s] = 0;
            node_on[s] = 0;
            free_ids[free_cnt++] = s;
            step_rsp.push_back(mk(0, STAT_DONE, 0, 0, 1));
         end
         KIND_ADD_EDGE: begin
            if (!node_ok(s) || !node_ok(d))
               step_rsp.push_back(mk(0, STAT_REJECT, 0, 0, 1));
            else if (edge_there(s, d))
               step_rsp.push_back(mk(0, STAT_DUP, 0, 0, 1));
            else if (node_deg[s] >= MAXDEG)
               step_rsp.push_back(mk(0, STAT_FULL, 0, 0, 1));
            else begin
               p = edge_pos(s, d);
               for (int i = node_deg[s]; i > p; i--) seg[s][i] = seg[s][i-1];
               seg[s][p] = d;
               node_deg[s]++;
               step_rsp.push_back(mk(0, STAT_DONE, 0, 0, 1));
            end
         end
         KIND_DEL_EDGE: begin
            if (!node_ok(s) || !edge_drop(s, d))
               step_rsp.push_back(mk(0, STAT_REJECT, 0, 0, 1));
            else
               step_rsp.push_back(mk(0, STAT_DONE, 0, 0, 1));
         end
         KIND_TEST: begin
            if (node_ok(s) && edge_there(s, d))
               step_rsp.push_back(mk(0, STAT_DONE, 1, 0, 1));
            else
               step_rsp.push_back(mk(0, STAT_REJECT, 0, 0, 1));
         end
         KIND_LIST: begin
            if (!node_ok(s))
               step_rsp.push_back(mk(0, STAT_REJECT, 0, 0, 1));
            else if (node_deg[s] == 0)
               step_rsp.push_back(mk(0, STAT_DONE, 0, 0, 1));
            else
               for (int i = 0; i < node_deg[s]; i++)
                  step_rsp.push_back(mk(0, STAT_DONE, 1, seg[s][i], i + 1 == node_deg[s]));
         end
         default: begin
            graph_reset();
            step_rsp.push_back(mk(0, STAT_DONE, 0, 0, 1));
         end
      endcase
   endfunction

   // typed rows carry their expected result, the rest are predicted
   task automatic send_item(kind_type k, int s, int d, bit typed = 0,
                            status_type st = STAT_DONE, int id = 0);
      while ($urandom_range(99) < snd_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= k;
      req_tdata <= {2'b00, d[6:0], s[6:0]};
      do @(posedge clock); while (!req_tready);
      graph_step(k, s, d);
      items_sent++;
      if (typed) pending_rsp.push_back(mk(id, st, 0, 0, 1));
      else foreach (step_rsp[i]) pending_rsp.push_back(step_rsp[i]);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic int pick_id();
      if (hiwater > 0 && $urandom_range(9) < 8) return $urandom_range(hiwater - 1);
      return $urandom_range(127);
   endfunction

   task automatic random_item();
      int r;
      r = $urandom_range(99);
      if (r < 15) send_item(KIND_ADD_NODE, $urandom_range(127), $urandom_range(127));
      else if (r < 20) send_item(KIND_DEL_NODE, pick_id(), $urandom_range(127));
      else if (r < 25) send_item(KIND_DEL_KEEP, pick_id(), $urandom_range(127));
      else if (r < 60) send_item(KIND_ADD_EDGE, pick_id(), pick_id());
      else if (r < 70) send_item(KIND_DEL_EDGE, pick_id(), pick_id());
      else if (r < 85) send_item(KIND_TEST, pick_id(), pick_id());
      else if (r < 99) send_item(KIND_LIST, pick_id(), $urandom_range(127));
      else send_item(KIND_CLEAR, $urandom_range(127), $urandom_range(127));
   endtask

   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= rcv_stall);

   always @(posedge clock) begin
      graph_rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_seen++;
         got = mk(rsp_tdata[5:0], status_type'(rsp_tdata[7:6]), rsp_tdata[8],
                  rsp_tdata[14:9], rsp_tlast);
         if (pending_rsp.size() == 0) begin
            report_mismatch("item with nothing expected");
         end else begin
            want = pending_rsp.pop_front();
            if (got.node_id !== want.node_id)
               report_mismatch($sformatf("node_id %0d want %0d", got.node_id, want.node_id));
            if (got.status !== want.status)
               report_mismatch($sformatf("status %0d want %0d", got.status, want.status));
            if (got.found !== want.found)
               report_mismatch($sformatf("found %0b want %0b", got.found, want.found));
            if (got.dest !== want.dest)
               report_mismatch($sformatf("dest %0d want %0d", got.dest, want.dest));
            if (got.last !== want.last)
               report_mismatch($sformatf("last %0b want %0b", got.last, want.last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   table_row_type rows[] = '{
      '{KIND_CLEAR,    0,   0,   1, STAT_DONE,   0},
      '{KIND_LIST,     0,   0,   1, STAT_REJECT, 0},
      '{KIND_ADD_NODE, 0,   0,   1, STAT_DONE,   0},
      '{KIND_ADD_NODE, 127, 127, 1, STAT_DONE,   1},
      '{KIND_ADD_NODE, 0,   0,   1, STAT_DONE,   2},
      '{KIND_ADD_EDGE, 0,   2,   0, STAT_DONE,   0},
      '{KIND_ADD_EDGE, 0,   1,   0, STAT_DONE,   0},
      '{KIND_ADD_EDGE, 0,   1,   1, STAT_DUP,    0},
      '{KIND_ADD_EDGE, 0,   127, 1, STAT_REJECT, 0},
      '{KIND_ADD_EDGE, 127, 0,   1, STAT_REJECT, 0},
      '{KIND_TEST,     0,   1,   0, STAT_DONE,   0},
      '{KIND_TEST,     0,   3,   1, STAT_REJECT, 0},
      '{KIND_LIST,     0,   0,   0, STAT_DONE,   0},
      '{KIND_LIST,     1,   0,   1, STAT_DONE,   0},
      '{KIND_DEL_EDGE, 0,   2,   0, STAT_DONE,   0},
      '{KIND_DEL_EDGE, 0,   2,   1, STAT_REJECT, 0},
      '{KIND_ADD_EDGE, 1,   0,   0, STAT_DONE,   0},
      '{KIND_ADD_EDGE, 2,   0,   0, STAT_DONE,   0},
      '{KIND_DEL_KEEP, 0,   0,   0, STAT_DONE,   0},
      '{KIND_ADD_NODE, 0,   0,   1, STAT_DONE,   0},
      '{KIND_TEST,     1,   0,   0, STAT_DONE,   0},
      '{KIND_DEL_NODE, 0,   0,   0, STAT_DONE,   0},
      '{KIND_TEST,     1,   0,   1, STAT_REJECT, 0},
      '{KIND_LIST,     127, 0,   1, STAT_REJECT, 0},
      '{KIND_DEL_NODE, 127, 0,   1, STAT_REJECT, 0},
      '{KIND_DEL_KEEP, 63,  0,   1, STAT_REJECT, 0},
      '{KIND_CLEAR,    127, 127, 1, STAT_DONE,   0}
   };

   initial begin
      int phase_snd[4] = '{0, 66, 0, 18};
      int phase_rcv[4] = '{0, 0, 66, 18};
      graph_reset();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i])
         send_item(rows[i].kind, rows[i].src, rows[i].dst, rows[i].typed,
                   rows[i].status, rows[i].node_id);
      drain();

      // fill one node to full degree in shuffled order, then list it
      for (int i = 0; i < 33; i++) send_item(KIND_ADD_NODE, 0, 0);
      for (int i = 0; i < 32; i++) send_item(KIND_ADD_EDGE, 0, 32 - ((i * 7) % 32));
      send_item(KIND_ADD_EDGE, 0, 0);
      send_item(KIND_LIST, 0, 0);
      // exhaust the node slots
      for (int i = 0; i < 32; i++) send_item(KIND_ADD_NODE, 0, 0);
      send_item(KIND_ADD_EDGE, 63, 0);
      send_item(KIND_DEL_NODE, 17, 0);
      send_item(KIND_LIST, 0, 0);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         snd_idle = phase_snd[ph];
         rcv_stall = phase_rcv[ph];
         for (int i = 0; i < 33; i++) random_item();
         drain();
      end
      snd_idle = 0;
      rcv_stall = 0;
      repeat (200) @(posedge clock);
      if (pending_rsp.size() != 0) report_mismatch("results never arrived");

      $display("covered %0d items and %0d result items over four handshake phases",
               items_sent, rsp_seen);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
+incdir+hdl
hdl/sas_pkg.sv
hdl/sas_datapath.sv
hdl/sas_control.sv
hdl/sorted_adjacency_store_unit.sv
tb/sorted_adjacency_store_unit_tb.sv
